// ===== design/checked_int64_alu_top_macros.svh =====
// Assertion macros for the checker file.
`ifndef CHECKED_INT64_ALU_TOP_MACROS_SVH
`define CHECKED_INT64_ALU_TOP_MACROS_SVH

// Implication checked outside reset.
`define CIA_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle consequence, checked during reset as well.
`define CIA_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/cia_pkg.sv =====
// Types and constants of the checked 64-bit integer ALU.
package cia_pkg;
   localparam int DATA_W    = 64;
   localparam int ACC_W     = 2 * DATA_W;
   localparam int NUM_CELLS = DATA_W;

   localparam logic [1:0] FUNC_ADD = 2'd0;
   localparam logic [1:0] FUNC_SUB = 2'd1;
   localparam logic [1:0] FUNC_MUL = 2'd2;
   localparam logic [1:0] FUNC_DIV = 2'd3;

   typedef struct packed {
      logic [1:0]               func;
      logic                     left_is_int;
      logic signed [DATA_W-1:0] left_value;
      logic                     right_is_int;
      logic signed [DATA_W-1:0] right_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result_value;
      logic                     fallback;
   } rsp_type;

   // One item in flight through the cell row.
   typedef struct packed {
      logic              valid;
      logic [1:0]        func;
      logic              fail;
      logic              neg;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic [ACC_W-1:0]  acc;
   } stage_type;
endpackage

// ===== design/cia_prep.sv =====
// Entry stage: operand checks, add/subtract, magnitude setup for the cell row.
module cia_prep import cia_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      req_fire,
   input  req_type   req_item,
   output stage_type stage_out
);
   logic [DATA_W-1:0] x, y, amag, bmag, sum, diff;
   logic              add_ovf, sub_ovf, fail;
   logic [ACC_W-1:0]  acc_init;
   logic              valid_ff, valid_in;
   stage_type         data_ff, data_in;

   always_comb begin
      x    = req_item.left_value;
      y    = req_item.right_value;
      amag = x[DATA_W-1] ? (~x + 1'b1) : x;
      bmag = y[DATA_W-1] ? (~y + 1'b1) : y;
      sum  = x + y;
      diff = x - y;
      add_ovf = (x[DATA_W-1] == y[DATA_W-1]) && (sum[DATA_W-1] != x[DATA_W-1]);
      sub_ovf = (x[DATA_W-1] != y[DATA_W-1]) && (diff[DATA_W-1] != x[DATA_W-1]);
      fail = !req_item.left_is_int || !req_item.right_is_int;
      acc_init = '0;
      unique case (req_item.func)
         FUNC_ADD: begin
            fail = fail || add_ovf;
            acc_init = {{DATA_W{1'b0}}, sum};
         end
         FUNC_SUB: begin
            fail = fail || sub_ovf;
            acc_init = {{DATA_W{1'b0}}, diff};
         end
         FUNC_MUL: acc_init = '0;
         FUNC_DIV: begin
            fail = fail || (y == '0);
            acc_init = {{DATA_W{1'b0}}, amag};
         end
         default: acc_init = '0;
      endcase
      data_in       = '0;
      data_in.func  = req_item.func;
      data_in.fail  = fail;
      data_in.neg   = x[DATA_W-1] ^ y[DATA_W-1];
      data_in.a     = amag;
      data_in.b     = bmag;
      data_in.acc   = acc_init;
      valid_in      = advance ? req_fire : valid_ff;
   end

   // Hold the item while the row is stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   always_comb begin
      stage_out       = data_ff;
      stage_out.valid = valid_ff;
   end
endmodule

// ===== design/cia_cell.sv =====
// One cell of the row: one shift-add multiply step or one restoring divide step.
module cia_cell import cia_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  stage_type stage_in,
   output stage_type stage_out
);
   logic [ACC_W:0]    msum;
   logic [ACC_W-1:0]  t;
   logic              valid_ff;
   stage_type         data_ff, data_in;

   always_comb begin
      data_in = stage_in;
      msum = {1'b0, stage_in.acc}
           + (stage_in.b[0] ? {1'b0, stage_in.a, {DATA_W{1'b0}}} : '0);
      t = {stage_in.acc[ACC_W-2:0], 1'b0};
      if (t[ACC_W-1:DATA_W] >= stage_in.b) begin
         t[ACC_W-1:DATA_W] = t[ACC_W-1:DATA_W] - stage_in.b;
         t[0] = 1'b1;
      end
      case (stage_in.func)
         FUNC_MUL: begin
            data_in.acc = msum[ACC_W:1];
            data_in.b   = stage_in.b >> 1;
         end
         FUNC_DIV: data_in.acc = t;
         default:  data_in.acc = stage_in.acc;
      endcase
   end

   // Advance valid with the whole row.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   always_comb begin
      stage_out       = data_ff;
      stage_out.valid = valid_ff;
   end
endmodule

// ===== design/checked_int64_alu_top.sv =====
// Top level of the checked 64-bit integer ALU.
// Usage:
//   req channel carries func and two tagged operands; rsp channel returns
//   result_value and fallback, one rsp item per req item, in order.
//   fallback is set, with a zero result, on a non-integer operand, on
//   signed 64-bit overflow, or on division by zero; division truncates.
// Path: an accepted req item is registered in the entry stage, then passes
//   through 64 cells that each take one multiplier or quotient bit, and is
//   then registered in the output stage, where rsp_valid is raised.
// Throughput: one item per cycle while the row is not stalled; the row of
//   64 cells is pipelined and each cell can hold a different item.
// Reset: clears all valid bits; no item is in flight afterwards.
// Stall: while rsp_valid is high and rsp_ready low the whole row holds and
//   req_ready is low; a waiting result does not block acceptance once the
//   receiver takes it in the same cycle.
module checked_int64_alu_top import cia_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_item
);
   stage_type         stages [0:NUM_CELLS];
   logic              advance;
   logic              hi_ovf, lim_ovf, fail;
   logic [DATA_W-1:0] mag, res;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   cia_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .req_fire  (req_valid && req_ready),
      .req_item  (req_item),
      .stage_out (stages[0])
   );

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      cia_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_in  (stages[i]),
         .stage_out (stages[i+1])
      );
   end

   // Range check and sign restore at the end of the row.
   always_comb begin
      mag     = stages[NUM_CELLS].acc[DATA_W-1:0];
      hi_ovf  = (stages[NUM_CELLS].func == FUNC_MUL)
             && (stages[NUM_CELLS].acc[ACC_W-1:DATA_W] != '0);
      lim_ovf = mag[DATA_W-1]
             && !(stages[NUM_CELLS].neg && (mag[DATA_W-2:0] == '0));
      fail    = stages[NUM_CELLS].fail;
      res     = mag;
      case (stages[NUM_CELLS].func) inside
         FUNC_MUL, FUNC_DIV: begin
            fail = fail || hi_ovf || lim_ovf;
            res  = stages[NUM_CELLS].neg ? (~mag + 1'b1) : mag;
         end
         default: res = mag;
      endcase
      rsp_in.fallback     = fail;
      rsp_in.result_value = fail ? '0 : res;
      rsp_valid_in        = advance ? stages[NUM_CELLS].valid : rsp_valid_ff;
   end

   // Hold the result until the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
endmodule

// ===== design/cia_checker.sv =====
// Port-level assertions for the checked 64-bit integer ALU, bound to the top.
`include "checked_int64_alu_top_macros.svh"
module cia_checker import cia_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_item,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_item
);
   `CIA_ASSERT_NXT(a_reset_empty, reset, !rsp_valid, "rsp_valid after reset")
   `CIA_ASSERT_IMP(a_fallback_zero, rsp_valid && rsp_item.fallback, rsp_item.result_value == '0, "fallback with nonzero result")
   `CIA_ASSERT_IMP(a_ready_rule, 1'b1, req_ready == (!rsp_valid || rsp_ready), "req_ready does not track the output stage")
   `CIA_ASSERT_NXT(a_rsp_hold, !reset && rsp_valid && !rsp_ready, reset || (rsp_valid && $stable(rsp_item)), "stalled rsp item changed")
endmodule

bind checked_int64_alu_top cia_checker u_cia_checker (.*);
